// ===== hw/rtl/mpfs_pkg.sv =====
// package for the pwm fade scheduler: sizes, codes, shared types
// no dependencies
package mpfs_pkg;
   localparam int CHANNELS = 15;
   localparam int FRAMES = 2;
   localparam int PIN_W = 4;
   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [11:0] MAX_LEVEL = 12'hFFF;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_ADD   = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_LOCK  = 3'd3;
   localparam logic [2:0] ACT_QUERY = 3'd4;

   localparam logic KIND_PWM = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // divider request and answer
   typedef struct packed {
      logic        start;
      logic [44:0] dividend;   // magnitude of elapsed*diff
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [44:0] quotient;
      logic        rem_nz;
   } div_rsp_type;
endpackage

// ===== hw/rtl/mpfs_divider.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on mpfs_pkg
module mpfs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mpfs_pkg::div_req_type req,
   output mpfs_pkg::div_rsp_type rsp
);
   import mpfs_pkg::*;

   logic [44:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quot_ff[44]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd45;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[43:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[43:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;
   assign rsp.rem_nz   = (rem_ff != '0);
endmodule

// ===== hw/rtl/multichannel_pwm_fade_scheduler.sv =====
// pwm fade scheduler top level: sequencer, channel and frame state
// depends on mpfs_pkg and mpfs_divider
// a status beat goes through S_STATUS and S_EMIT after accept; a write with a pwm update first
// passes S_WRITE and its own S_EMIT; one item at a time, next accept only back in S_IDLE
// tick: S_FRAME scans each frame, S_DIV per divide, S_WRITE per write, S_EMIT per pwm beat (held by stalls)
// synchronous active-high reset clears levels, locks, frame busy bits and the ms counter
module multichannel_pwm_fade_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // action[2:0] pin_index[6:3] level[22:7] span_ms[38:23] delay_ms[54:39] lock_request[55]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_pin[3:0] out_level[15:4] locked_flag[16] ok[17] zero fill
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast   // last
);
   import mpfs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_FRAME  = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_WRITE  = 7'b0001000,
      S_STATUS = 7'b0010000,
      S_EMIT   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [11:0] lvl_ff [CHANNELS];
   logic [CHANNELS-1:0] lock_ff;
   logic [FRAMES-1:0]   busy_ff;
   logic [PIN_W-1:0]    fpin_ff  [FRAMES];
   logic [11:0]         fst_ff   [FRAMES];
   logic [15:0]         fend_ff  [FRAMES];
   logic [31:0]         ftime_ff [FRAMES];
   logic [15:0]         fspan_ff [FRAMES];
   logic [31:0]         now_ff;

   // latched request
   logic [2:0]  act_ff;
   logic [3:0]  pin_ff;
   logic [15:0] rlevel_ff;
   logic [15:0] rspan_ff;
   logic [15:0] rdelay_ff;
   logic        rlock_ff;

   logic [FRAME_W:0] fidx_ff;       // frame scan counter, can hold FRAMES
   logic              neg_ff;
   logic [15:0]       wval_ff;      // value to write in S_WRITE
   logic [PIN_W-1:0]  wpin_ff;
   logic              wfree_ff;     // free frame after the write

   // output beat register, only loaded while no beat is pending
   logic        ov_ff;
   logic [3:0]  opin_ff;
   logic [11:0] olvl_ff;
   logic        olk_ff, ook_ff, okind_ff, olast_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   mpfs_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [FRAME_W-1:0] fi;
   assign fi = fidx_ff[FRAME_W-1:0];

   // frame classification for current scan index
   logic [31:0] fin, elapsed;
   logic signed [16:0] diff;
   logic [16:0] dmag;
   logic [48:0] prod;
   always_comb begin
      fin     = ftime_ff[fi] + {16'd0, fspan_ff[fi]};
      elapsed = now_ff - ftime_ff[fi];
      diff    = $signed({1'b0, fend_ff[fi]}) - $signed({5'd0, fst_ff[fi]});
      dmag    = diff[16] ? 17'(-diff) : 17'(diff);
      prod    = 49'(elapsed * dmag[15:0]); // |diff| fits 16 bits
   end

   // signed interpolation result
   logic [45:0] qmag;
   logic signed [47:0] q;
   always_comb begin
      qmag = {1'b0, drsp.quotient} + {45'd0, neg_ff & drsp.rem_nz};
      q    = neg_ff ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag});
      q    = q + $signed({36'd0, fst_ff[fi]});
   end

   logic pin_ok;
   assign pin_ok = ({1'b0, pin_ff} < 5'(CHANNELS));
   logic [PIN_W-1:0] pidx;
   assign pidx = pin_ff[PIN_W-1:0];

   logic [FRAME_W:0] free_idx;
   logic             have_free;
   always_comb begin
      free_idx  = '0;
      have_free = 1'b0;
      for (int f = FRAMES - 1; f >= 0; f--) begin
         if (!busy_ff[f]) begin
            free_idx  = (FRAME_W + 1)'(f);
            have_free = 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, ook_ff, olk_ff, olvl_ff, opin_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   logic [11:0] sat;
   assign sat = (wval_ff > 16'(MAX_LEVEL)) ? MAX_LEVEL : wval_ff[11:0];

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      dreq.start    = 1'b0;
      dreq.dividend = {prod[44:0]};
      dreq.divisor  = fspan_ff[fi];
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = (req_tdata[2:0] == ACT_TICK) ? S_FRAME :
                                            (req_tdata[2:0] == ACT_WRITE) ? S_WRITE : S_STATUS;
         S_FRAME: begin
            if (fidx_ff == (FRAME_W + 1)'(FRAMES)) state_in = S_STATUS;
            else if (busy_ff[fi] && (now_ff > fin ||
                     (now_ff >= ftime_ff[fi] && fspan_ff[fi] == '0))) state_in = S_WRITE;
            else if (busy_ff[fi] && now_ff >= ftime_ff[fi]) begin
               dreq.start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV:    if (drsp.done) state_in = S_WRITE;
         S_WRITE: begin
            if (!lock_ff[wpin_ff] && {1'b0, wpin_ff} < 5'(CHANNELS)) begin
               state_in = S_EMIT;
               ret_in = (act_ff == ACT_TICK) ? S_FRAME : S_STATUS;
            end else state_in = (act_ff == ACT_TICK) ? S_FRAME : S_STATUS;
         end
         S_STATUS: begin
            state_in = S_EMIT;
            ret_in = S_DONE;
         end
         // leave only once the beat has been taken, so the beat register is free again
         S_EMIT:   if (ov_ff && rsp_tready) state_in = ret_ff;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         ov_ff    <= 1'b0;
         lock_ff  <= '0;
         busy_ff  <= '0;
         now_ff   <= '0;
         fidx_ff  <= '0;
         for (int c = 0; c < CHANNELS; c++) lvl_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               act_ff    <= req_tdata[2:0];
               pin_ff    <= req_tdata[6:3];
               rlevel_ff <= req_tdata[22:7];
               rspan_ff  <= req_tdata[38:23];
               rdelay_ff <= req_tdata[54:39];
               rlock_ff  <= req_tdata[55];
               wval_ff   <= req_tdata[22:7];
               wpin_ff   <= req_tdata[PIN_W+2:3];
               wfree_ff  <= 1'b0;
               fidx_ff   <= '0;
               if (req_tdata[2:0] == ACT_TICK) now_ff <= now_ff + 32'd1;
            end
            S_FRAME: if (fidx_ff != (FRAME_W + 1)'(FRAMES)) begin
               wpin_ff  <= fpin_ff[fi];
               neg_ff   <= diff[16];
               if (busy_ff[fi] && (now_ff > fin ||
                   (now_ff >= ftime_ff[fi] && fspan_ff[fi] == '0))) begin
                  wval_ff  <= fend_ff[fi];
                  wfree_ff <= 1'b1;
               end else if (!(busy_ff[fi] && now_ff >= ftime_ff[fi]))
                  fidx_ff <= fidx_ff + (FRAME_W + 1)'(1);
            end
            S_DIV: if (drsp.done) begin
               wfree_ff <= 1'b0;
               wval_ff  <= q[47] ? 16'd0 : (q > 48'sd4095) ? 16'(MAX_LEVEL) : q[15:0];
            end
            S_WRITE: begin
               if (act_ff == ACT_TICK) begin
                  fidx_ff <= fidx_ff + (FRAME_W + 1)'(1);
                  if (wfree_ff) busy_ff[fi] <= 1'b0;
               end
               if (!lock_ff[wpin_ff] && {1'b0, wpin_ff} < 5'(CHANNELS)) begin
                  lvl_ff[wpin_ff] <= sat;
                  okind_ff <= KIND_PWM;
                  opin_ff  <= wpin_ff;
                  olvl_ff  <= sat;
                  olk_ff   <= 1'b0;
                  ook_ff   <= 1'b1;
                  olast_ff <= 1'b0;
               end
            end
            S_STATUS: begin
               okind_ff <= KIND_STATUS;
               olast_ff <= 1'b1;
               opin_ff  <= '0;
               olvl_ff  <= '0;
               olk_ff   <= 1'b0;
               ook_ff   <= 1'b0;
               if (act_ff == ACT_TICK) ook_ff <= 1'b1;
               else if (act_ff > ACT_QUERY) ook_ff <= 1'b0;
               else if (!pin_ok) opin_ff <= pin_ff;
               else begin
                  opin_ff <= pin_ff;
                  olvl_ff <= lvl_ff[pidx];
                  olk_ff  <= lock_ff[pidx];
                  ook_ff  <= 1'b1;
                  case (act_ff)
                     ACT_ADD: begin
                        ook_ff <= have_free;
                        if (have_free) begin
                           busy_ff[free_idx[FRAME_W-1:0]]  <= 1'b1;
                           fpin_ff[free_idx[FRAME_W-1:0]]  <= pidx;
                           fst_ff[free_idx[FRAME_W-1:0]]   <= lvl_ff[pidx];
                           fend_ff[free_idx[FRAME_W-1:0]]  <= rlevel_ff;
                           ftime_ff[free_idx[FRAME_W-1:0]] <= now_ff + {16'd0, rdelay_ff};
                           fspan_ff[free_idx[FRAME_W-1:0]] <= rspan_ff;
                        end
                     end
                     ACT_WRITE: ook_ff <= !lock_ff[pidx];
                     ACT_LOCK: begin
                        lock_ff[pidx] <= rlock_ff;
                        olk_ff <= rlock_ff;
                     end
                     default: ;
                  endcase
               end
            end
            // beat register is always empty on entry; raise valid once
            S_EMIT: if (!ov_ff) ov_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

// ===== hw/rtl/mpfs_checker.sv =====
// port-level checker for the pwm fade scheduler, bound to the top level
// depends on nothing
module mpfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   // status beats carry last, pwm beats never do
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast)) else $error("last/kind mismatch");
   // a pwm beat always reports ok and unlocked
   a_pwm_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[17] && !rsp_tdata[16]) else $error("bad pwm beat");
   // no new request taken in the cycle after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("back-to-back accept");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("beat dropped");
endmodule

bind multichannel_pwm_fade_scheduler mpfs_checker u_chk (.*);

// ===== verif/multichannel_pwm_fade_scheduler_tb.sv =====
// testbench for the pwm fade scheduler: directed and random actions, in-order result checking
// depends on mpfs_pkg and the multichannel_pwm_fade_scheduler rtl
module multichannel_pwm_fade_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpfs_pkg::*;

   localparam logic [2:0] ACT_BAD = 3'd5;

   typedef struct {
      logic        kind;
      logic [3:0]  pin;
      logic [11:0] lvl;
      logic        lk;
      logic        ok;
      logic        last;
   } beat_t;

   // fade engine predictor and queue of expected result beats
   class fade_scoreboard;
      logic [11:0] level_q[CHANNELS];
      logic        lock_q[CHANNELS];
      logic        busy_q[FRAMES];
      logic [3:0]  fpin[FRAMES];
      logic [11:0] fstart[FRAMES];
      logic [15:0] fend[FRAMES];
      logic [31:0] ftime[FRAMES];
      logic [15:0] fspan[FRAMES];
      logic [31:0] now;
      beat_t       pending[$];
      int          mismatches;

      function new();
         for (int i = 0; i < CHANNELS; i++) begin
            level_q[i] = '0;
            lock_q[i] = 1'b0;
         end
         for (int f = 0; f < FRAMES; f++) begin
            busy_q[f] = 1'b0;
         end
         now = '0;
         mismatches = 0;
      endfunction

      function void push(logic kind, logic [3:0] pin, logic [11:0] lvl, logic lk, logic ok,
                         logic last);
         beat_t b;
         b.kind = kind; b.pin = pin; b.lvl = lvl; b.lk = lk; b.ok = ok; b.last = last;
         pending.push_back(b);
      endfunction

      // saturating write, suppressed on a locked pin
      function logic drive_pin(logic [3:0] pin, logic [31:0] value);
         logic [11:0] sat;
         if (lock_q[pin]) return 1'b0;
         sat = (value > 32'd4095) ? MAX_LEVEL : value[11:0];
         level_q[pin] = sat;
         push(KIND_PWM, pin, sat, 1'b0, 1'b1, 1'b0);
         return 1'b1;
      endfunction

      function void note_input(logic [55:0] d);
         logic [2:0]  act;
         logic [3:0]  pin;
         logic [15:0] lvl, span, dly;
         logic        lreq, ok, dummy;
         logic [31:0] fin, el;
         longint      diff, prod, q;
         act = d[2:0]; pin = d[6:3]; lvl = d[22:7]; span = d[38:23]; dly = d[54:39];
         lreq = d[55];
         if (act == ACT_TICK) begin
            now = now + 32'd1;
            for (int f = 0; f < FRAMES; f++) begin
               if (!busy_q[f]) continue;
               fin = ftime[f] + {16'd0, fspan[f]};
               if (now > fin || (now >= ftime[f] && fspan[f] == 0)) begin
                  dummy = drive_pin(fpin[f], {16'd0, fend[f]});
                  busy_q[f] = 1'b0;
                  continue;
               end
               if (now < ftime[f]) continue;
               el = now - ftime[f];
               diff = longint'(fend[f]) - longint'(fstart[f]);
               prod = longint'(el) * diff;
               q = prod / longint'(fspan[f]);
               if (prod < 0 && q * longint'(fspan[f]) != prod) q -= 1;
               q += longint'(fstart[f]);
               if (q < 0) q = 0;
               if (q > 4095) q = 4095;
               dummy = drive_pin(fpin[f], q[31:0]);
            end
            push(KIND_STATUS, 4'd0, 12'd0, 1'b0, 1'b1, 1'b1);
            return;
         end
         if (act > ACT_QUERY) begin
            push(KIND_STATUS, 4'd0, 12'd0, 1'b0, 1'b0, 1'b1);
            return;
         end
         if (pin >= CHANNELS) begin
            push(KIND_STATUS, pin, 12'd0, 1'b0, 1'b0, 1'b1);
            return;
         end
         ok = 1'b1;
         if (act == ACT_ADD) begin
            ok = 1'b0;
            for (int f = 0; f < FRAMES; f++) begin
               if (!busy_q[f]) begin
                  busy_q[f] = 1'b1; fpin[f] = pin; fstart[f] = level_q[pin];
                  fend[f] = lvl; ftime[f] = now + {16'd0, dly}; fspan[f] = span;
                  ok = 1'b1;
                  break;
               end
            end
         end else if (act == ACT_WRITE) begin
            ok = drive_pin(pin, {16'd0, lvl});
         end else if (act == ACT_LOCK) begin
            lock_q[pin] = lreq;
         end
         push(KIND_STATUS, pin, level_q[pin], lock_q[pin], ok, 1'b1);
      endfunction

      function void check_result(logic [23:0] d, logic kind, logic last);
         beat_t e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat data=%h", d);
            return;
         end
         e = pending.pop_front();
         if (e.kind !== kind || e.pin !== d[3:0] || e.lvl !== d[15:4] || e.lk !== d[16] ||
             e.ok !== d[17] || e.last !== last || d[23:18] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind=%0d pin=%0d lvl=%0d lk=%0d ok=%0d last=%0d, got kind=%0d pin=%0d lvl=%0d lk=%0d ok=%0d last=%0d fill=%h",
                        e.kind, e.pin, e.lvl, e.lk, e.ok, e.last,
                        kind, d[3:0], d[15:4], d[16], d[17], last, d[23:18]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   fade_scoreboard board = new();
   bit          stim_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multichannel_pwm_fade_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // mostly short gaps, an occasional long one, and some gap-free stretches
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // one request beat: optional idle gap, then hold tvalid until accepted
   task automatic send_action(logic [2:0] act, logic [3:0] pin, logic [15:0] lvl,
                              logic [15:0] span, logic [15:0] dly, logic lreq);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lreq, dly, span, lvl, pin, act};
      do @(posedge clock); while (!req_tready);
      board.note_input({lreq, dly, span, lvl, pin, act});
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic tick_n(int n);
      for (int i = 0; i < n; i++) send_action(ACT_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
   endtask

   // random beat with a random pin, full-width fields apart from the mostly short add spans and delays
   task automatic send_random();
      int r;
      logic [3:0] pin;
      r = $urandom_range(0, 99);
      pin = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(15, 15)) : 4'($urandom_range(0, 14));
      if (r < 40)
         send_action(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 62)
         // mostly short fades so they run to completion within the run
         send_action(ACT_ADD, pin, 16'($urandom),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
                     1'($urandom));
      else if (r < 77)
         send_action(ACT_WRITE, pin, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 87)
         send_action(ACT_LOCK, pin, 16'($urandom), 16'($urandom), 16'($urandom),
                     ($urandom_range(0, 2) == 0));
      else if (r < 97)
         send_action(ACT_QUERY, pin, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else
         send_action(3'($urandom_range(5, 7)), pin, 16'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
   endtask

   // result side: random stalls, check on every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      int g;
      @(posedge clock);
      while (1) begin
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every action, locks, full table, zero span, out-of-range pin
      send_action(ACT_WRITE, 4'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
      send_action(ACT_WRITE, 4'd14, 16'd4095, 16'hFFFF, 16'hFFFF, 1'b1);
      send_action(ACT_WRITE, 4'd15, 16'd100, 16'd0, 16'd0, 1'b0);
      send_action(ACT_QUERY, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_action(ACT_BAD, 4'd3, 16'd1, 16'd1, 16'd1, 1'b1);
      send_action(3'd7, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // falling fade on pin 0, rising fade on pin 1, then table full
      send_action(ACT_ADD, 4'd0, 16'd0, 16'd3, 16'd0, 1'b0);
      send_action(ACT_ADD, 4'd1, 16'hFFFF, 16'd7, 16'd1, 1'b0);
      send_action(ACT_ADD, 4'd2, 16'd5, 16'd5, 16'd0, 1'b0);
      tick_n(10);
      // zero-span fade and a fade onto a locked pin
      send_action(ACT_LOCK, 4'd5, 16'd0, 16'd0, 16'd0, 1'b1);
      send_action(ACT_WRITE, 4'd5, 16'd9, 16'd0, 16'd0, 1'b0);
      send_action(ACT_ADD, 4'd5, 16'd700, 16'd2, 16'd0, 1'b0);
      send_action(ACT_ADD, 4'd6, 16'd1234, 16'd0, 16'd2, 1'b0);
      tick_n(4);
      send_action(ACT_LOCK, 4'd5, 16'd0, 16'd0, 16'd0, 1'b0);
      send_action(ACT_QUERY, 4'd5, 16'd0, 16'd0, 16'd0, 1'b0);

      // hold off until the block has delivered everything
      drain_wait();

      for (int i = 0; i < 200; i++) begin
         send_random();
         if (i == 100) drain_wait();
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("multichannel_pwm_fade_scheduler_tb: done, clean");
      else
         $display("multichannel_pwm_fade_scheduler_tb: done, errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("multichannel_pwm_fade_scheduler_tb: done, errors");
      $finish;
   end
endmodule
